FILE: design/markup_tag_strip_filter_defines.svh
// markup_tag_strip_filter_defines.svh: assertion macros for the tag strip filter.
// No dependencies; included by modules that carry concurrent checks.
`ifndef MARKUP_TAG_STRIP_FILTER_DEFINES_SVH
`define MARKUP_TAG_STRIP_FILTER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MTSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtsf check failed");

// Antecedent implies consequent on the next cycle.
`define MTSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtsf check failed");

`endif

FILE: design/mtsf_pkg.sv
// mtsf_pkg: constants, types and helpers for the markup tag strip filter.
// No dependencies; used by mtsf_datapath, mtsf_ctrl and markup_tag_strip_filter.
package mtsf_pkg;

    localparam int TOKEN_DEPTH = 32;
    localparam int LEN_W       = $clog2(TOKEN_DEPTH + 1);
    localparam int IDX_W       = $clog2(TOKEN_DEPTH);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_F_LOW  = 8'h66;

    // Action selected by the first two tag bytes.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WRAP,
        ACT_REF_OPEN,
        ACT_REF_CLOSE,
        ACT_NUMBER,
        ACT_GT,
        ACT_LINE,
        ACT_PARA
    } mtsf_act_t;

    // Source of the next output word.
    typedef enum logic [2:0] {
        EM_INPUT,
        EM_ZERO,
        EM_HEAD,
        EM_TAIL,
        EM_RAM,
        EM_ACC
    } mtsf_emit_t;

    typedef struct packed {
        logic       take;
        logic       emit_en;
        logic       emit_last;
        mtsf_emit_t emit_sel;
        logic       fix_idx;
        logic       idx_init;
        logic       idx_inc;
        logic       rd_en;
        logic       acc_clr;
        logic       acc_dig;
        logic       neg_load;
    } mtsf_cmd_t;

    typedef struct packed {
        logic      in_zero;
        logic      in_open;
        logic      in_close;
        logic      in_tag;
        mtsf_act_t act;
        logic      head_two;
        logic      idx_end;
        logic      rd_ws;
        logic      rd_sign;
        logic      rd_digit;
        logic      out_free;
    } mtsf_sts_t;

    // Fixed bytes around a tag: head bytes, or the two tail bytes of a wrap.
    function automatic logic [7:0] fixed_byte(mtsf_act_t act, logic tail, logic idx);
        logic [7:0] res;
        res = CH_NUL;
        if (tail)
            res = idx ? CH_SPACE : CH_GT;
        else
        begin
            case (act)
                ACT_WRAP:      res = idx ? CH_LT : CH_SPACE;
                ACT_REF_OPEN:  res = idx ? CH_LBRACK : CH_SPACE;
                ACT_REF_CLOSE: res = idx ? CH_SPACE : CH_RBRACK;
                ACT_GT:        res = CH_GT;
                ACT_LINE:      res = CH_NL;
                ACT_PARA:      res = CH_NL;
                default:       res = CH_NUL;
            endcase
        end
        return res;
    endfunction

endpackage

FILE: design/mtsf_in_if.sv
// mtsf_in_if: input byte channel (valid/ready) of the tag strip filter.
// No dependencies.
interface mtsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

FILE: design/mtsf_out_if.sv
// mtsf_out_if: output byte channel (valid/ready) of the tag strip filter.
// No dependencies.
interface mtsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: design/mtsf_ram.sv
// mtsf_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module mtsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mtsf_datapath.sv
// mtsf_datapath: tag store, length, index, number accumulator and output word.
// Depends on mtsf_pkg and mtsf_ram.
module mtsf_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            text_byte,
    input  mtsf_pkg::mtsf_cmd_t   cmd,
    output mtsf_pkg::mtsf_sts_t   sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  last_of_run
);

    logic                       in_tag_reg, in_tag_next;
    logic [mtsf_pkg::LEN_W-1:0] len_reg, len_next;
    logic [mtsf_pkg::LEN_W-1:0] ridx_reg, ridx_next;
    logic [7:0]                 b0_reg, b0_next;
    logic [7:0]                 b1_reg, b1_next;
    logic [7:0]                 acc_reg, acc_next;
    logic                       neg_reg, neg_next;
    logic [7:0]                 ob_reg, ob_next;
    logic                       olast_reg, olast_next;
    logic                       ovalid_reg, ovalid_next;

    logic       in_zero, in_open, in_close, collect_wr;
    logic [7:0] rd_data, tag_a, tag_b, acc_x8, acc_x2, acc_neg;
    mtsf_pkg::mtsf_act_t act;

    mtsf_ram #(
        .WIDTH (8),
        .DEPTH (mtsf_pkg::TOKEN_DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (collect_wr),
        .waddr (len_reg[mtsf_pkg::IDX_W-1:0]),
        .wdata (text_byte),
        .re    (cmd.rd_en),
        .raddr (ridx_reg[mtsf_pkg::IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign in_zero    = (text_byte == mtsf_pkg::CH_NUL);
    assign in_open    = (text_byte == mtsf_pkg::CH_LT);
    assign in_close   = (text_byte == mtsf_pkg::CH_GT);
    assign collect_wr = cmd.take && in_tag_reg && !in_zero && !in_open && !in_close
                        && (len_reg < mtsf_pkg::LEN_W'(mtsf_pkg::TOKEN_DEPTH));

    // missing tag bytes read as zero
    assign tag_a = (len_reg != '0) ? b0_reg : mtsf_pkg::CH_NUL;
    assign tag_b = (len_reg > mtsf_pkg::LEN_W'(1)) ? b1_reg : mtsf_pkg::CH_NUL;

    always_comb
    begin
        act = mtsf_pkg::ACT_NONE;
        if (tag_a == mtsf_pkg::CH_W && (tag_b == mtsf_pkg::CH_G || tag_b == mtsf_pkg::CH_H
                                        || tag_b == mtsf_pkg::CH_T))
            act = mtsf_pkg::ACT_WRAP;
        else if (tag_a == mtsf_pkg::CH_R && tag_b == mtsf_pkg::CH_F)
            act = mtsf_pkg::ACT_REF_OPEN;
        else if (tag_a == mtsf_pkg::CH_R && tag_b == mtsf_pkg::CH_F_LOW)
            act = mtsf_pkg::ACT_REF_CLOSE;
        else if (tag_a == mtsf_pkg::CH_C)
        begin
            if (tag_b == mtsf_pkg::CH_A)
                act = mtsf_pkg::ACT_NUMBER;
            else if (tag_b == mtsf_pkg::CH_G)
                act = mtsf_pkg::ACT_GT;
            else if (tag_b == mtsf_pkg::CH_L || tag_b == mtsf_pkg::CH_N)
                act = mtsf_pkg::ACT_LINE;
            else if (tag_b == mtsf_pkg::CH_M)
                act = mtsf_pkg::ACT_PARA;
        end
    end

    always_comb
    begin
        sts          = '0;
        sts.in_zero  = in_zero;
        sts.in_open  = in_open;
        sts.in_close = in_close;
        sts.in_tag   = in_tag_reg;
        sts.act      = act;
        sts.head_two = (act != mtsf_pkg::ACT_GT) && (act != mtsf_pkg::ACT_LINE);
        sts.idx_end  = (ridx_reg >= len_reg);
        sts.rd_digit = (rd_data >= mtsf_pkg::CH_0) && (rd_data <= mtsf_pkg::CH_9);
        sts.rd_sign  = (rd_data == mtsf_pkg::CH_PLUS) || (rd_data == mtsf_pkg::CH_MINUS);
        case (rd_data) inside
            mtsf_pkg::CH_SPACE, mtsf_pkg::CH_TAB, mtsf_pkg::CH_NL,
            mtsf_pkg::CH_VT, mtsf_pkg::CH_FF, mtsf_pkg::CH_CR: sts.rd_ws = 1'b1;
            default:                                           sts.rd_ws = 1'b0;
        endcase
        sts.out_free = !ovalid_reg || out_ready;
    end

    // tag state
    always_comb
    begin
        in_tag_next = in_tag_reg;
        len_next    = len_reg;
        b0_next     = b0_reg;
        b1_next     = b1_reg;
        if (cmd.take)
        begin
            if (in_zero)
            begin
                in_tag_next = 1'b0;
                len_next    = '0;
            end
            else if (in_open)
            begin
                in_tag_next = 1'b1;
                len_next    = '0;
            end
            else if (in_close)
                in_tag_next = 1'b0;
        end
        if (collect_wr)
        begin
            len_next = len_reg + mtsf_pkg::LEN_W'(1);
            if (len_reg == '0)
                b0_next = text_byte;
            if (len_reg == mtsf_pkg::LEN_W'(1))
                b1_next = text_byte;
        end
    end

    // body index and decimal accumulator
    assign acc_x8  = {acc_reg[4:0], 3'b000};
    assign acc_x2  = {acc_reg[6:0], 1'b0};
    assign acc_neg = ~acc_reg + 8'd1;

    always_comb
    begin
        ridx_next = ridx_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        if (cmd.idx_init)
            ridx_next = mtsf_pkg::LEN_W'(2);
        else if (cmd.idx_inc)
            ridx_next = ridx_reg + mtsf_pkg::LEN_W'(1);
        if (cmd.acc_clr)
        begin
            acc_next = 8'd0;
            neg_next = 1'b0;
        end
        else if (cmd.acc_dig)
            acc_next = acc_x8 + acc_x2 + {4'b0000, rd_data[3:0]};
        if (cmd.neg_load)
            neg_next = (rd_data == mtsf_pkg::CH_MINUS);
    end

    // output word
    always_comb
    begin
        ob_next     = ob_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !out_ready;
        if (cmd.emit_en)
        begin
            ovalid_next = 1'b1;
            olast_next  = cmd.emit_last;
            unique case (cmd.emit_sel)
                mtsf_pkg::EM_INPUT: ob_next = text_byte;
                mtsf_pkg::EM_ZERO:  ob_next = mtsf_pkg::CH_NUL;
                mtsf_pkg::EM_HEAD:  ob_next = mtsf_pkg::fixed_byte(act, 1'b0, cmd.fix_idx);
                mtsf_pkg::EM_TAIL:  ob_next = mtsf_pkg::fixed_byte(act, 1'b1, cmd.fix_idx);
                mtsf_pkg::EM_RAM:   ob_next = rd_data;
                mtsf_pkg::EM_ACC:   ob_next = neg_reg ? acc_neg : acc_reg;
                default:            ob_next = mtsf_pkg::CH_NUL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tag_reg <= 1'b0;
            len_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            in_tag_reg <= in_tag_next;
            len_reg    <= len_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg  <= ridx_next;
        b0_reg    <= b0_next;
        b1_reg    <= b1_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        ob_reg    <= ob_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = ovalid_reg;
    assign out_byte    = ob_reg;
    assign last_of_run = olast_reg;

endmodule

FILE: design/mtsf_ctrl.sv
// mtsf_ctrl: sequencer for input intake, tag expansion and number parsing.
// Depends on mtsf_pkg and markup_tag_strip_filter_defines.svh.
`include "markup_tag_strip_filter_defines.svh"

module mtsf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mtsf_pkg::mtsf_sts_t sts,
    output mtsf_pkg::mtsf_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HEAD  = 8'b0000_0010,
        S_BRD   = 8'b0000_0100,
        S_BOUT  = 8'b0000_1000,
        S_TAIL  = 8'b0001_0000,
        S_PRD   = 8'b0010_0000,
        S_PEVAL = 8'b0100_0000,
        S_CAOUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   hidx_reg, hidx_next;    // position within head or tail pair
    logic   dig_reg, dig_next;      // sign or digit seen, no more whitespace

    assign in_ready = (state_reg == S_IDLE) && sts.out_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        hidx_next  = hidx_reg;
        dig_next   = dig_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && sts.out_free)
                begin
                    cmd.take = 1'b1;
                    if (sts.in_zero)
                    begin
                        cmd.emit_en   = 1'b1;
                        cmd.emit_last = 1'b1;
                        cmd.emit_sel  = mtsf_pkg::EM_ZERO;
                    end
                    else if (sts.in_close)
                    begin
                        if (sts.act == mtsf_pkg::ACT_NUMBER)
                        begin
                            cmd.idx_init = 1'b1;
                            cmd.acc_clr  = 1'b1;
                            dig_next     = 1'b0;
                            state_next   = S_PRD;
                        end
                        else if (sts.act != mtsf_pkg::ACT_NONE)
                        begin
                            hidx_next  = 1'b0;
                            state_next = S_HEAD;
                        end
                    end
                    else if (!sts.in_open && !sts.in_tag)
                    begin
                        cmd.emit_en   = 1'b1;
                        cmd.emit_last = 1'b1;
                        cmd.emit_sel  = mtsf_pkg::EM_INPUT;
                    end
                end
            end
            S_HEAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_en  = 1'b1;
                    cmd.emit_sel = mtsf_pkg::EM_HEAD;
                    cmd.fix_idx  = hidx_reg;
                    if (hidx_reg || !sts.head_two)
                    begin
                        if (sts.act == mtsf_pkg::ACT_WRAP)
                        begin
                            cmd.idx_init = 1'b1;
                            state_next   = S_BRD;
                        end
                        else
                        begin
                            cmd.emit_last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    else
                        hidx_next = 1'b1;
                end
            end
            S_BRD:
            begin
                if (sts.idx_end)
                begin
                    hidx_next  = 1'b0;
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_BOUT;
                end
            end
            S_BOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_en  = 1'b1;
                    cmd.emit_sel = mtsf_pkg::EM_RAM;
                    cmd.idx_inc  = 1'b1;
                    state_next   = S_BRD;
                end
            end
            S_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_en  = 1'b1;
                    cmd.emit_sel = mtsf_pkg::EM_TAIL;
                    cmd.fix_idx  = hidx_reg;
                    if (hidx_reg)
                    begin
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                        hidx_next = 1'b1;
                end
            end
            S_PRD:
            begin
                if (sts.idx_end)
                    state_next = S_CAOUT;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_PEVAL;
                end
            end
            S_PEVAL:
            begin
                if (!dig_reg && sts.rd_ws)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_PRD;
                end
                else if (!dig_reg && sts.rd_sign)
                begin
                    cmd.neg_load = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    dig_next     = 1'b1;
                    state_next   = S_PRD;
                end
                else if (sts.rd_digit)
                begin
                    cmd.acc_dig = 1'b1;
                    cmd.idx_inc = 1'b1;
                    dig_next    = 1'b1;
                    state_next  = S_PRD;
                end
                else
                    state_next = S_CAOUT;
            end
            S_CAOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_en   = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_sel  = mtsf_pkg::EM_ACC;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hidx_reg  <= 1'b0;
            dig_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hidx_reg  <= hidx_next;
            dig_reg   <= dig_next;
        end
    end

    `MTSF_ASSERT_IMPL(a_emit_slot_free, clk, rst_n, cmd.emit_en, sts.out_free)
    `MTSF_ASSERT_IMPL(a_read_in_body, clk, rst_n, cmd.rd_en, !sts.idx_end)
    `MTSF_ASSERT_NEXT(a_last_ends_run, clk, rst_n, cmd.emit_en && cmd.emit_last, state_reg == S_IDLE)

endmodule

FILE: design/markup_tag_strip_filter.sv
// markup_tag_strip_filter: top level of the markup tag strip filter.
// Depends on mtsf_pkg, mtsf_in_if, mtsf_out_if, mtsf_ctrl and mtsf_datapath.
//
//   channel   dir   payload                     word
//   text_in   in    text_byte[7:0]              one text character
//   text_out  out   out_byte[7:0], last_of_run  one filtered character
//
// A plain byte is passed through; '<' and a collected tag byte emit nothing.
// A closing '>' of a known tag emits its head bytes at one per cycle while the
// output is free; a wrap tag then reads each body byte from the tag RAM and
// outputs it, finds the body end, then emits the two tail bytes; a numeric tag
// reads and parses its body characters, then emits the result word.
// rst_n clears tag state and the output valid flag; the tag RAM needs no clearing.
// Output back-pressure holds the sequencer; input is taken only when idle.
module markup_tag_strip_filter (
    input logic        clk,
    input logic        rst_n,
    mtsf_in_if.sink    text_in,
    mtsf_out_if.source text_out
);

    mtsf_pkg::mtsf_cmd_t cmd;
    mtsf_pkg::mtsf_sts_t sts;

    // sequencer: input intake, expansion and parse steps
    mtsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tag store, accumulator and registered output word
    mtsf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_in.text_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (text_out.valid),
        .out_ready   (text_out.ready),
        .out_byte    (text_out.out_byte),
        .last_of_run (text_out.last_of_run)
    );

endmodule
